// ----- src/fisr_pkg.sv -----
// Shared constants and binary32 helper functions for the inverse square root pipeline.
package fisr_pkg;

    localparam logic [31:0] MAGIC_K   = 32'h5f3759df;
    localparam logic [31:0] NAN_CANON = 32'h7FC00000;
    localparam logic [31:0] ONE_HALF  = 32'h3F000000;
    localparam logic [31:0] THREE_HALVES = 32'h3FC00000;

    // Operand unpacked for multiplication: significand with hidden bit and an
    // unsigned biased exponent (value = sig * 2^(exp - 150)).
    typedef struct packed {
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic [9:0]  exp;
        logic [23:0] sig;
    } fp_unp_t;

    // Product after the multiplier stage, before rounding.
    typedef struct packed {
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic signed [10:0] exp;
        logic [47:0] prod;
    } fp_prod_t;

    function automatic fp_unp_t fp_unpack(input logic [31:0] a);
        fp_unp_t u;
        u.sign    = a[31];
        u.is_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        u.is_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        u.is_zero = (a[30:0] == 31'd0);
        if (a[30:23] == 8'd0)
        begin
            u.exp = 10'd1;
            u.sig = {1'b0, a[22:0]};
        end
        else
        begin
            u.exp = {2'b00, a[30:23]};
            u.sig = {1'b1, a[22:0]};
        end
        return u;
    endfunction

    // Round a nonzero magnitude m * 2^(e - 150 - 23) to binary32, RNE.
    // m is 48 bits; leading-one search covers that width in one priority loop.
    function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
                                             input logic [47:0] m);
        logic [5:0]  lz;
        logic        found;
        logic signed [12:0] be;
        logic [47:0] n;
        logic [74:0] w;
        logic [12:0] sh;
        logic [23:0] keep;
        logic        g;
        logic        st;
        logic [24:0] r;
        logic [8:0]  ef;
        logic [31:0] res;
        lz = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                found = 1'b1;
                lz = 6'(47 - i);
            end
        end
        n = m << lz;
        // n[47] is the leading one; biased exponent of that value
        be = 13'(e) - 13'(lz) + 13'sd1;
        if (be >= 13'sd1)
        begin
            keep = n[47:24];
            g    = n[23];
            st   = |n[22:0];
            ef   = 9'(be);
        end
        else
        begin
            sh = 13'sd1 - be;
            w  = {n, 27'd0};
            if (sh > 13'd26)
                w = {74'd0, |w};
            else
                w = (w >> sh[4:0]) | {74'd0, |(w & ~({75{1'b1}} << sh[4:0]))};
            keep = w[74:51];
            g    = w[50];
            st   = |w[49:0];
            ef   = 9'd0;
        end
        r = {1'b0, keep} + 25'(g && (st || keep[0]));
        if (r[24])
        begin
            r  = r >> 1;
            ef = ef + 9'd1;
        end
        else if (ef == 9'd0 && r[23])
            ef = 9'd1;
        if (ef >= 9'd255)
            res = {sign, 8'hFF, 23'd0};
        else
            res = {sign, ef[7:0], r[22:0]};
        return res;
    endfunction

    // Finish a product: specials, then rounding.
    function automatic logic [31:0] fp_mul_finish(input fp_prod_t p);
        logic [31:0] res;
        if (p.is_nan)
            res = NAN_CANON;
        else if (p.is_inf)
            res = {p.sign, 8'hFF, 23'd0};
        else if (p.is_zero || p.prod == 48'd0)
            res = {p.sign, 31'd0};
        else
            res = fp_round(p.sign, 12'(p.exp), p.prod);
        return res;
    endfunction

    // Multiplier front end: specials and the raw significand product.
    function automatic fp_prod_t fp_mul_start(input logic [31:0] a, input logic [31:0] b);
        fp_unp_t  ua;
        fp_unp_t  ub;
        fp_prod_t p;
        ua = fp_unpack(a);
        ub = fp_unpack(b);
        p.sign    = ua.sign ^ ub.sign;
        p.is_nan  = ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero)
                    || (ub.is_inf && ua.is_zero);
        p.is_inf  = ua.is_inf || ub.is_inf;
        p.is_zero = ua.is_zero || ub.is_zero;
        // The product is prod * 2^(exp_a + exp_b - 300), which is prod * 2^(e - 173).
        p.exp     = 11'(ua.exp) + 11'(ub.exp) - 11'sd127;
        p.prod    = ua.sig * ub.sig;
        return p;
    endfunction

    // Front end of 1.5 - t: specials, alignment and the unrounded magnitude.
    // Both significands sit at bits 46:23; the operand with the smaller exponent
    // is shifted right with its lost bits folded into a sticky lsb.
    function automatic fp_prod_t fp_sub_start(input logic [31:0] t);
        fp_unp_t     u;
        fp_prod_t    p;
        logic [47:0] hi_m;
        logic [47:0] lo_m;
        logic [47:0] a15;
        logic [47:0] at;
        logic [8:0]  k;
        logic        t_big;
        u = fp_unpack(t);
        t_big = (u.exp >= 10'd127);
        if (t_big)
        begin
            hi_m  = {1'b0, u.sig, 23'd0};
            lo_m  = {1'b0, THREE_HALVES[22:0] | 24'h800000, 23'd0};
            k     = 9'(u.exp - 10'd127);
            p.exp = 11'(u.exp);
        end
        else
        begin
            hi_m  = {1'b0, THREE_HALVES[22:0] | 24'h800000, 23'd0};
            lo_m  = {1'b0, u.sig, 23'd0};
            k     = 9'(10'd127 - u.exp);
            p.exp = 11'sd127;
        end
        if (k >= 9'd47)
            lo_m = {47'd0, |lo_m};
        else
            lo_m = (lo_m >> k) | {47'd0, |(lo_m & ~({48{1'b1}} << k))};
        a15 = t_big ? lo_m : hi_m;
        at  = t_big ? hi_m : lo_m;
        if (u.sign)
        begin
            p.prod = a15 + at;
            p.sign = 1'b0;
        end
        else if (a15 >= at)
        begin
            p.prod = a15 - at;
            p.sign = 1'b0;
        end
        else
        begin
            p.prod = at - a15;
            p.sign = 1'b1;
        end
        p.is_nan  = u.is_nan;
        p.is_inf  = u.is_inf;
        p.is_zero = 1'b0;
        if (u.is_inf)
            p.sign = !u.sign;
        return p;
    endfunction

endpackage

// ----- src/fisr_mul_stage.sv -----
// Two-register binary32 multiplier: product register, then rounding register.
module fisr_mul_stage
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] side_in,
    output logic        out_valid,
    output logic [31:0] prod_bits,
    output logic [31:0] side_out
);

    fisr_pkg::fp_prod_t prod_reg;
    logic               v1_reg;
    logic [31:0]        side1_reg;
    logic               v2_reg;
    logic [31:0]        res_reg;
    logic [31:0]        side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= fisr_pkg::fp_mul_start(a, b);
            side1_reg <= side_in;
            res_reg   <= fisr_pkg::fp_mul_finish(prod_reg);
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign prod_bits = res_reg;
    assign side_out  = side2_reg;

endmodule

// ----- src/fast_inverse_sqrt_float32.sv -----
// Top level of the pipelined fast inverse square root.
// Usage: present a binary32 word on operand_bits with in_valid; it is taken when in_ready
// is high. The result word appears on rsqrt_bits with out_valid and is held until
// out_ready. One word enters per cycle while in_ready is high.
// Register stages: guess (1), halving multiply (2), half*y (2), *y (2), 1.5 minus
// alignment and add (1), its rounding (1), y* (2), NaN fold and output register (1).
// The whole pipe advances together; a stalled receiver freezes every stage, so nothing
// is lost or repeated. in_ready falls only when the output register holds a word that
// is not being taken. The 24x24 significand multiply in each multiplier stage sets the
// cycle time.
// Reset clears all valid bits; payload registers are not reset. The block keeps no state
// between words.
module fast_inverse_sqrt_float32
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] rsqrt_bits
);

    logic               en;
    logic               s0_v_reg;
    logic [31:0]        s0_half_reg;
    logic [31:0]        s0_y_reg;
    logic               m1_v;
    logic [31:0]        m1_p;
    logic [31:0]        m1_y;
    logic               m2_v;
    logic [31:0]        m2_p;
    logic [31:0]        m2_y;
    logic               s3_v_reg;
    fisr_pkg::fp_prod_t s3_sum_reg;
    logic [31:0]        s3_y_reg;
    logic               s4_v_reg;
    logic [31:0]        s4_t_reg;
    logic [31:0]        s4_y_reg;
    logic               m3_v;
    logic [31:0]        m3_p;
    logic [31:0]        m3_unused;
    logic               out_v_reg;
    logic [31:0]        out_reg;
    logic [31:0]        shifted;

    assign en       = !out_v_reg || out_ready;
    assign in_ready = en;
    assign shifted  = {operand_bits[31], operand_bits[31:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg  <= in_valid;
            s3_v_reg  <= m2_v;
            s4_v_reg  <= s3_v_reg;
            out_v_reg <= m3_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_half_reg <= operand_bits;
            s0_y_reg    <= fisr_pkg::MAGIC_K - shifted;
            s3_sum_reg  <= fisr_pkg::fp_sub_start(m2_p);
            s3_y_reg    <= m2_y;
            s4_t_reg    <= fisr_pkg::fp_mul_finish(s3_sum_reg);
            s4_y_reg    <= s3_y_reg;
            if (m3_p[30:23] == 8'hFF && m3_p[22:0] != 23'd0)
                out_reg <= fisr_pkg::NAN_CANON;
            else
                out_reg <= m3_p;
        end
    end

    // First product is half*y computed as (0.5*x) rounded then times y; the
    // half product rides in its own multiplier ahead of the main chain.
    logic        h_v;
    logic [31:0] h_p;
    logic [31:0] h_y;

    fisr_mul_stage u_half
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s0_v_reg), .a(fisr_pkg::ONE_HALF), .b(s0_half_reg), .side_in(s0_y_reg),
        .out_valid(h_v), .prod_bits(h_p), .side_out(h_y)
    );

    fisr_mul_stage u_mul1
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(h_v), .a(h_p), .b(h_y), .side_in(h_y),
        .out_valid(m1_v), .prod_bits(m1_p), .side_out(m1_y)
    );

    fisr_mul_stage u_mul2
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(m1_v), .a(m1_p), .b(m1_y), .side_in(m1_y),
        .out_valid(m2_v), .prod_bits(m2_p), .side_out(m2_y)
    );

    fisr_mul_stage u_mul3
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s4_v_reg), .a(s4_y_reg), .b(s4_t_reg), .side_in(s4_y_reg),
        .out_valid(m3_v), .prod_bits(m3_p), .side_out(m3_unused)
    );

    assign out_valid  = out_v_reg;
    assign rsqrt_bits = out_reg;

endmodule
